FILE: rtl/actk_pkg.sv
// Shared types and constants for the light cull and top-K selection block.
// Used by actk_front, actk_cell and aabb_cull_top_k_select_top.
`default_nettype none

package actk_pkg;

  localparam int unsigned IdW     = 16;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned LenW    = 23;
  localparam int unsigned RankW   = 16;
  localparam int unsigned DistW   = 50;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCameraX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCameraY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegViewHalfW   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegViewHalfH   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegViewMargin  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCullDisable = 3'd5;

  localparam logic [LenW-1:0] MarginReset = 23'd25600;

  // One stored light.
  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [DistW-1:0] dist_sq;
    logic [IdW-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic [CoordW-1:0] camera_x;
    logic [CoordW-1:0] camera_y;
    logic [LenW-1:0]   half_w;
    logic [LenW-1:0]   half_h;
    logic [LenW-1:0]   margin;
    logic              cull_disable;
  } cfg_t;

  // Light leaving the cull and distance pipeline.
  typedef struct packed {
    logic   valid;
    logic   pass;
    logic   last;
    entry_t entry;
  } front_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/actk_front.sv
// Cull and distance pipeline: box overlap test and squared camera distance.
// Depends on actk_pkg.
`default_nettype none

module actk_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          take_i,
  input  wire actk_pkg::cfg_t                cfg_i,
  input  wire logic [actk_pkg::IdW-1:0]      light_id_i,
  input  wire logic [actk_pkg::CoordW-1:0]   pos_x_i,
  input  wire logic [actk_pkg::CoordW-1:0]   pos_y_i,
  input  wire logic [actk_pkg::LenW-1:0]     reach_i,
  input  wire logic [actk_pkg::LenW-1:0]     size_x_i,
  input  wire logic [actk_pkg::LenW-1:0]     size_y_i,
  input  wire logic [actk_pkg::RankW-1:0]    rank_i,
  input  wire logic                          last_light_i,
  output actk_pkg::front_t                   front_o
);

  // All box coordinates are in doubled units so that size/2 stays exact.
  logic signed [26:0] lo_x_d, hi_x_d, lo_y_d, hi_y_d;
  logic signed [26:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic signed [24:0] dx_d, dy_d, dx_q, dy_q;
  logic [24:0]        ext_x, ext_y;
  logic [24:0]        view_w, view_h;
  logic signed [26:0] vlo_x, vhi_x, vlo_y, vhi_y;
  logic               s1_valid_q, s1_last_q;
  logic [actk_pkg::IdW-1:0]   s1_id_q, s2_id_q;
  logic [actk_pkg::RankW-1:0] s1_rank_q, s2_rank_q;
  logic               s2_valid_q, s2_last_q, s2_pass_q, pass_d;
  logic signed [49:0] sqx_full, sqy_full;
  logic [47:0]        sqx_q, sqy_q;
  logic               out_valid_q, out_pass_q, out_last_q;
  actk_pkg::entry_t   out_entry_q;

  always_comb begin
    ext_x  = {1'b0, reach_i, 1'b0} + {2'b00, size_x_i};
    ext_y  = {1'b0, reach_i, 1'b0} + {2'b00, size_y_i};
    lo_x_d = $signed({{2{pos_x_i[23]}}, pos_x_i, 1'b0}) - $signed({2'b00, ext_x});
    hi_x_d = $signed({{2{pos_x_i[23]}}, pos_x_i, 1'b0}) + $signed({2'b00, ext_x});
    lo_y_d = $signed({{2{pos_y_i[23]}}, pos_y_i, 1'b0}) - $signed({2'b00, ext_y});
    hi_y_d = $signed({{2{pos_y_i[23]}}, pos_y_i, 1'b0}) + $signed({2'b00, ext_y});
    dx_d   = $signed({pos_x_i[23], pos_x_i}) - $signed({cfg_i.camera_x[23], cfg_i.camera_x});
    dy_d   = $signed({pos_y_i[23], pos_y_i}) - $signed({cfg_i.camera_y[23], cfg_i.camera_y});
  end

  // View box edges follow the static configuration.
  always_comb begin
    view_w = {({1'b0, cfg_i.half_w} + {1'b0, cfg_i.margin}), 1'b0};
    view_h = {({1'b0, cfg_i.half_h} + {1'b0, cfg_i.margin}), 1'b0};
    vlo_x  = $signed({{2{cfg_i.camera_x[23]}}, cfg_i.camera_x, 1'b0})
             - $signed({2'b00, view_w});
    vhi_x  = $signed({{2{cfg_i.camera_x[23]}}, cfg_i.camera_x, 1'b0})
             + $signed({2'b00, view_w});
    vlo_y  = $signed({{2{cfg_i.camera_y[23]}}, cfg_i.camera_y, 1'b0})
             - $signed({2'b00, view_h});
    vhi_y  = $signed({{2{cfg_i.camera_y[23]}}, cfg_i.camera_y, 1'b0})
             + $signed({2'b00, view_h});
    pass_d = cfg_i.cull_disable ||
             ((lo_x_q <= vhi_x) && (hi_x_q >= vlo_x) &&
              (lo_y_q <= vhi_y) && (hi_y_q >= vlo_y));
    sqx_full = dx_q * dx_q;
    sqy_full = dy_q * dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= take_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_x_q    <= lo_x_d;
    hi_x_q    <= hi_x_d;
    lo_y_q    <= lo_y_d;
    hi_y_q    <= hi_y_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    s1_id_q   <= light_id_i;
    s1_rank_q <= rank_i;
    s1_last_q <= last_light_i;

    s2_pass_q <= pass_d;
    sqx_q     <= sqx_full[47:0];
    sqy_q     <= sqy_full[47:0];
    s2_id_q   <= s1_id_q;
    s2_rank_q <= s1_rank_q;
    s2_last_q <= s1_last_q;

    out_pass_q          <= s2_pass_q;
    out_last_q          <= s2_last_q;
    out_entry_q.dist_sq <= {2'b00, sqx_q} + {2'b00, sqy_q};
    out_entry_q.id      <= s2_id_q;
    out_entry_q.rank    <= s2_rank_q;
  end

  assign front_o = {out_valid_q, out_pass_q, out_last_q, out_entry_q};

endmodule

`default_nettype wire

FILE: rtl/actk_cell.sv
// One slot of the sorted light store; shifts right on insert, left on drain.
// Depends on actk_pkg.
`default_nettype none

module actk_cell (
  input  wire logic                 clk_i,
  input  wire actk_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                 occupied_i,
  input  wire actk_pkg::entry_t     new_i,
  input  wire logic                 left_flag_i,
  input  wire actk_pkg::entry_t     left_i,
  input  wire actk_pkg::entry_t     right_i,
  output logic                      flag_o,
  output actk_pkg::entry_t          entry_o
);

  actk_pkg::entry_t entry_q;
  logic             worse;

  // The stored light ranks strictly below the new one.
  always_comb begin
    if (entry_q.rank != new_i.rank) begin
      worse = $signed(entry_q.rank) < $signed(new_i.rank);
    end else begin
      worse = entry_q.dist_sq > new_i.dist_sq;
    end
    flag_o = !occupied_i || worse;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_out) begin
      entry_q <= right_i;
    end else if (ctrl_i.insert) begin
      if (left_flag_i) begin
        entry_q <= left_i;
      end else if (flag_o) begin
        entry_q <= new_i;
      end
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: rtl/aabb_cull_top_k_select_top.sv
// Top level of the light cull and top-K selection block.
// Depends on actk_pkg, actk_front and actk_cell.
`default_nettype none

// Each input item is one light. A three-stage pipeline tests its bounding box
// (position plus or minus reach + size/2) against the camera view box grown by
// the margin, inclusive at the edges, and computes the squared distance to the
// camera. A passing light then enters a row of MAX_SELECTED cells that holds
// the selected lights sorted by rank, highest first, then by distance, nearest
// first; equal keys keep arrival order and a full row drops its lowest entry.
// Input is never held off before a frame's last light is accepted, so lights
// stream at one per cycle. Once the light marked last_light is accepted, input
// is held off while it goes through the pipeline and the row, and then the row
// shifts out one selected id per output item from its head, with run_end on
// the final one. An empty frame gives one item with chosen_valid low and
// chosen_id zero. The next frame's first light is accepted in the cycle after
// the final output item is taken. Configuration registers are written through
// cfg_we_i, cfg_index_i and cfg_data_i; the user must write them only while
// the block is idle, which it does not enforce; unknown indexes are ignored.

module aabb_cull_top_k_select_top #(
  parameter int unsigned MAX_SELECTED = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            cfg_we_i,
  input  wire logic [actk_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [actk_pkg::CfgW-1:0]       cfg_data_i,

  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [actk_pkg::IdW-1:0]        light_id_i,
  input  wire logic [actk_pkg::CoordW-1:0]     pos_x_i,
  input  wire logic [actk_pkg::CoordW-1:0]     pos_y_i,
  input  wire logic [actk_pkg::LenW-1:0]       reach_i,
  input  wire logic [actk_pkg::LenW-1:0]       size_x_i,
  input  wire logic [actk_pkg::LenW-1:0]       size_y_i,
  input  wire logic [actk_pkg::RankW-1:0]      rank_i,
  input  wire logic                            last_light_i,

  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [actk_pkg::IdW-1:0]             chosen_id_o,
  output logic                                 chosen_valid_o,
  output logic                                 run_end_o
);

  localparam int unsigned CntW = $clog2(MAX_SELECTED + 1);

  actk_pkg::cfg_t       cfg_q;
  actk_pkg::front_t     front;
  actk_pkg::cell_ctrl_t ctrl;
  actk_pkg::entry_t     entries [MAX_SELECTED];
  logic [MAX_SELECTED-1:0] flags;

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic            drain_q, drain_d;
  logic            take, out_take;

  assign take        = in_valid_i && in_ready_o;
  assign in_ready_o  = !busy_q;
  assign out_take    = out_valid_o && out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x     <= '0;
      cfg_q.camera_y     <= '0;
      cfg_q.half_w       <= '0;
      cfg_q.half_h       <= '0;
      cfg_q.margin       <= actk_pkg::MarginReset;
      cfg_q.cull_disable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        actk_pkg::RegCameraX:     cfg_q.camera_x     <= cfg_data_i;
        actk_pkg::RegCameraY:     cfg_q.camera_y     <= cfg_data_i;
        actk_pkg::RegViewHalfW:   cfg_q.half_w       <= cfg_data_i[actk_pkg::LenW-1:0];
        actk_pkg::RegViewHalfH:   cfg_q.half_h       <= cfg_data_i[actk_pkg::LenW-1:0];
        actk_pkg::RegViewMargin:  cfg_q.margin       <= cfg_data_i[actk_pkg::LenW-1:0];
        actk_pkg::RegCullDisable: cfg_q.cull_disable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  actk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .cfg_i        (cfg_q),
    .light_id_i   (light_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .reach_i      (reach_i),
    .size_x_i     (size_x_i),
    .size_y_i     (size_y_i),
    .rank_i       (rank_i),
    .last_light_i (last_light_i),
    .front_o      (front)
  );

  // Every cell sees the new light; a cell whose left neighbor takes part in
  // the insertion shifts that neighbor's entry in, so the row stays sorted.
  always_comb begin
    ctrl.insert    = front.valid && front.pass;
    ctrl.shift_out = out_take && (count_q > CntW'(1));
  end

  for (genvar g = 0; g < MAX_SELECTED; g++) begin : g_cell
    actk_pkg::entry_t left_entry, right_entry;
    logic             left_flag;

    if (g == 0) begin : g_head
      assign left_flag  = 1'b0;
      assign left_entry = front.entry;
    end else begin : g_body
      assign left_flag  = flags[g-1];
      assign left_entry = entries[g-1];
    end

    if (g == MAX_SELECTED - 1) begin : g_tail
      assign right_entry = entries[g];
    end else begin : g_inner
      assign right_entry = entries[g+1];
    end

    actk_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(g)),
      .new_i       (front.entry),
      .left_flag_i (left_flag),
      .left_i      (left_entry),
      .right_i     (right_entry),
      .flag_o      (flags[g]),
      .entry_o     (entries[g])
    );
  end

  // Fill count, frame busy flag and drain control.
  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    drain_d = drain_q;
    if (take && last_light_i) begin
      busy_d = 1'b1;
    end
    if (ctrl.insert && flags[MAX_SELECTED-1] && (count_q < CntW'(MAX_SELECTED))) begin
      count_d = count_q + CntW'(1);
    end
    if (front.valid && front.last) begin
      drain_d = 1'b1;
    end
    if (out_take) begin
      if (count_q > CntW'(1)) begin
        count_d = count_q - CntW'(1);
      end else begin
        count_d = '0;
        drain_d = 1'b0;
        busy_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      drain_q <= drain_d;
    end
  end

  // Results come from the head cell of the row.
  assign out_valid_o    = drain_q;
  assign chosen_valid_o = (count_q != '0);
  assign chosen_id_o    = (count_q != '0) ? entries[0].id : '0;
  assign run_end_o      = (count_q <= CntW'(1));

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the light cull and top-K selection block.
// Depends on actk_pkg and aabb_cull_top_k_select_top, and through it on actk_front and actk_cell.

module testbench;

  localparam int MaxSel       = 32;
  localparam int SettleCycles = 8;       // pipeline plus row, with slack
  localparam int HoldCycles   = 400;     // long receiver stall for back-pressure
  localparam int SegLights    = 65;      // random lights per view setting
  localparam int CycleLimit   = 200000;

  // Indexes that select no register; writes to them must change nothing.
  localparam logic [actk_pkg::CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [actk_pkg::CfgIdxW-1:0] RegSpare7 = 3'd7;

  typedef struct packed {
    logic [actk_pkg::IdW-1:0]    id;
    logic [actk_pkg::CoordW-1:0] px;
    logic [actk_pkg::CoordW-1:0] py;
    logic [actk_pkg::LenW-1:0]   reach;
    logic [actk_pkg::LenW-1:0]   sx;
    logic [actk_pkg::LenW-1:0]   sy;
    logic [actk_pkg::RankW-1:0]  rank;
    logic                        last;
  } light_t;

  // One output item: the id of a chosen light, its valid flag and end of list.
  typedef struct packed {
    logic [actk_pkg::IdW-1:0] id;
    logic                     vld;
    logic                     fin;
  } pick_t;

  typedef struct packed {
    light_t l;
    logic   typed;
    pick_t  pick;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [actk_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [actk_pkg::CfgW-1:0]     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [actk_pkg::IdW-1:0]      light_id_i;
  logic [actk_pkg::CoordW-1:0]   pos_x_i;
  logic [actk_pkg::CoordW-1:0]   pos_y_i;
  logic [actk_pkg::LenW-1:0]     reach_i;
  logic [actk_pkg::LenW-1:0]     size_x_i;
  logic [actk_pkg::LenW-1:0]     size_y_i;
  logic [actk_pkg::RankW-1:0]    rank_i;
  logic                          last_light_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [actk_pkg::IdW-1:0]      chosen_id_o;
  logic                          chosen_valid_o;
  logic                          run_end_o;

  aabb_cull_top_k_select_top #(.MAX_SELECTED(MaxSel)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .light_id_i     (light_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .reach_i        (reach_i),
    .size_x_i       (size_x_i),
    .size_y_i       (size_y_i),
    .rank_i         (rank_i),
    .last_light_i   (last_light_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chosen_id_o    (chosen_id_o),
    .chosen_valid_o (chosen_valid_o),
    .run_end_o      (run_end_o)
  );

  // Our own copy of the view registers, kept in plain integers so that the
  // box test and the distance can be done exactly in 64 bits.
  longint v_cam_x, v_cam_y, v_half_w, v_half_h, v_margin;
  bit     v_cull_off;

  // Our own copy of the sorted selection store.
  int                       sel_rank [MaxSel];
  longint                   sel_dsq  [MaxSel];
  logic [actk_pkg::IdW-1:0] sel_id   [MaxSel];
  int                       sel_count;
  bit                       sel_overflow;

  pick_t     picks_due[$];     // output items still to arrive, oldest first
  pick_t     fresh_picks[$];   // output items caused by the light just taken
  plan_row_t plan[$];          // directed stimulus table

  int snd_idle_pct, rcv_idle_pct;
  bit hold_req;
  int errors, cycles;
  int lights_sent, frames_sent, picks_seen, empty_frames, overflow_frames;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Inclusive interval overlap, every term in doubled units so that half a
  // body size is never rounded.
  function automatic bit spans_overlap(input longint lc, lh, vc, vh);
    return (lc - lh <= vc + vh) && (lc + lh >= vc - vh);
  endfunction

  // Culls one light, files it into the selection store and, on the last
  // light of a frame, lists the output items that the frame produces.
  function automatic void admit_light(input light_t l);
    longint px, py, dx, dy, dsq;
    int     rk, pos, top, i;
    bit     pass;
    pick_t  p;
    px = longint'($signed(l.px));
    py = longint'($signed(l.py));
    rk = int'($signed(l.rank));
    fresh_picks.delete();
    if (v_cull_off) begin
      pass = 1'b1;
    end else begin
      pass = spans_overlap(2 * px, 2 * longint'(l.reach) + longint'(l.sx),
                           2 * v_cam_x, 2 * (v_half_w + v_margin)) &&
             spans_overlap(2 * py, 2 * longint'(l.reach) + longint'(l.sy),
                           2 * v_cam_y, 2 * (v_half_h + v_margin));
    end
    if (pass) begin
      dx = px - v_cam_x;
      dy = py - v_cam_y;
      dsq = dx * dx + dy * dy;
      // The new light goes in front of the first entry that ranks strictly
      // below it, so entries with equal keys keep their arrival order.
      pos = sel_count;
      i = 0;
      while (i < sel_count && pos == sel_count) begin
        if (sel_rank[i] != rk ? sel_rank[i] < rk : sel_dsq[i] > dsq) pos = i;
        i++;
      end
      if (sel_count == MaxSel) sel_overflow = 1'b1;
      if (pos < MaxSel) begin
        top = (sel_count < MaxSel) ? sel_count : MaxSel - 1;
        for (i = top; i > pos; i--) begin
          sel_rank[i] = sel_rank[i - 1];
          sel_dsq[i]  = sel_dsq[i - 1];
          sel_id[i]   = sel_id[i - 1];
        end
        sel_rank[pos] = rk;
        sel_dsq[pos]  = dsq;
        sel_id[pos]   = l.id;
        if (sel_count < MaxSel) sel_count++;
      end
    end
    if (l.last) begin
      if (sel_count == 0) begin
        p.id  = '0;
        p.vld = 1'b0;
        p.fin = 1'b1;
        fresh_picks = {fresh_picks, p};
        empty_frames++;
      end
      for (i = 0; i < sel_count; i++) begin
        p.id  = sel_id[i];
        p.vld = 1'b1;
        p.fin = (i == sel_count - 1);
        fresh_picks = {fresh_picks, p};
      end
      if (sel_overflow) overflow_frames++;
      sel_count = 0;
      sel_overflow = 1'b0;
      frames_sent++;
    end
  endfunction

  function automatic plan_row_t plan_row(input int id, px, py, reach, sx, sy, rank,
                                         input bit last, typed,
                                         input int t_id, input bit t_vld);
    plan_row_t r;
    r.l.id       = actk_pkg::IdW'(id);
    r.l.px       = actk_pkg::CoordW'(px);
    r.l.py       = actk_pkg::CoordW'(py);
    r.l.reach    = actk_pkg::LenW'(reach);
    r.l.sx       = actk_pkg::LenW'(sx);
    r.l.sy       = actk_pkg::LenW'(sy);
    r.l.rank     = actk_pkg::RankW'(rank);
    r.l.last     = last;
    r.typed      = typed;
    r.pick.id    = actk_pkg::IdW'(t_id);
    r.pick.vld   = t_vld;
    r.pick.fin   = 1'b1;
    return r;
  endfunction

  // Writes one register at the falling edge and mirrors it, masked to the
  // register's width, into the local view copy. Spare indexes are ignored.
  task automatic write_reg(input logic [actk_pkg::CfgIdxW-1:0] idx,
                           input logic [actk_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      actk_pkg::RegCameraX:     v_cam_x    = longint'($signed(val));
      actk_pkg::RegCameraY:     v_cam_y    = longint'($signed(val));
      actk_pkg::RegViewHalfW:   v_half_w   = longint'(val[actk_pkg::LenW-1:0]);
      actk_pkg::RegViewHalfH:   v_half_h   = longint'(val[actk_pkg::LenW-1:0]);
      actk_pkg::RegViewMargin:  v_margin   = longint'(val[actk_pkg::LenW-1:0]);
      actk_pkg::RegCullDisable: v_cull_off = val[0];
      default: ;
    endcase
  endtask

  // Sets the whole view. Bits above each register's width carry noise, which
  // the block has to drop.
  task automatic set_view(input int cx, cy, hw, hh, mg, input bit off);
    write_reg(actk_pkg::RegCameraX,     actk_pkg::CfgW'(cx));
    write_reg(actk_pkg::RegCameraY,     actk_pkg::CfgW'(cy));
    write_reg(actk_pkg::RegViewHalfW,   {1'($urandom), actk_pkg::LenW'(hw)});
    write_reg(actk_pkg::RegViewHalfH,   {1'($urandom), actk_pkg::LenW'(hh)});
    write_reg(actk_pkg::RegViewMargin,  {1'($urandom), actk_pkg::LenW'(mg)});
    write_reg(actk_pkg::RegCullDisable, {23'($urandom), off});
  endtask

  // Offers one light and waits until it is taken. The expected output items
  // come from the local predictor, or from the table where the row types
  // them in.
  task automatic send_light(input light_t l, input bit typed, input pick_t fixed);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    light_id_i   = l.id;
    pos_x_i      = l.px;
    pos_y_i      = l.py;
    reach_i      = l.reach;
    size_x_i     = l.sx;
    size_y_i     = l.sy;
    rank_i       = l.rank;
    last_light_i = l.last;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    admit_light(l);
    if (typed) begin
      fresh_picks = '{fixed};
    end
    picks_due = {picks_due, fresh_picks};
    lights_sent++;
  endtask

  // Waits until every expected item has come out, then lets the pipeline
  // settle so that register writes find the block idle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (picks_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Receiver: random ready at each falling edge, or a long hold-off when the
  // stimulus asks for one. The hold-off is counted here, in cycles.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Every output item taken is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_out
    pick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      picks_seen++;
      if (picks_due.size() == 0) begin
        $error("output item with nothing expected: chosen_id %h", chosen_id_o);
        errors++;
      end else begin
        want = picks_due.pop_front();
        if (chosen_id_o !== want.id) begin
          $error("chosen_id: expected %h, got %h", want.id, chosen_id_o);
          errors++;
        end
        if (chosen_valid_o !== want.vld) begin
          $error("chosen_valid: expected %b, got %b", want.vld, chosen_valid_o);
          errors++;
        end
        if (run_end_o !== want.fin) begin
          $error("run_end: expected %b, got %b", want.fin, run_end_o);
          errors++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int     seg, j, flen, seg_lights, kind;
    longint spx, spy;
    light_t lt;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    light_id_i   = '0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    reach_i      = '0;
    size_x_i     = '0;
    size_y_i     = '0;
    rank_i       = '0;
    last_light_i = 1'b0;
    hold_req     = 1'b0;
    errors       = 0;
    cycles       = 0;
    lights_sent  = 0;
    frames_sent  = 0;
    picks_seen   = 0;
    empty_frames = 0;
    overflow_frames = 0;
    sel_count    = 0;
    sel_overflow = 1'b0;
    v_cam_x      = 0;
    v_cam_y      = 0;
    v_half_w     = 0;
    v_half_h     = 0;
    v_margin     = longint'(actk_pkg::MarginReset);
    v_cull_off   = 1'b0;
    snd_idle_pct = 13;
    rcv_idle_pct = 63;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Writes to indexes past the last register must leave the reset view
    // alone, and the typed rows below rely on that.
    write_reg(RegSpare6, actk_pkg::CfgW'($urandom));
    write_reg(RegSpare7, actk_pkg::CfgW'($urandom));

    // Directed rows run on the reset view: camera at the origin, zero half
    // extents and a margin of 25600, so the view box spans -25600..25600 on
    // both axes. Single-light frames have their one output item typed in.
    plan = {plan, plan_row('h1234, 0, 0, 0, 0, 0, 0, 1, 1, 'h1234, 1)};
    // Far off to the right: nothing survives, so the frame reports empty.
    plan = {plan, plan_row('hFFFF, 8388607, 0, 0, 0, 0, 0, 1, 1, 0, 0)};
    // Left edge of the light box exactly on the right edge of the view.
    plan = {plan, plan_row(3, 25700, 0, 100, 0, 0, 32767, 1, 1, 3, 1)};
    plan = {plan, plan_row(4, 25701, 0, 100, 0, 0, 32767, 1, 1, 0, 0)};
    // Half a body size decides the touch, so it must not be rounded.
    plan = {plan, plan_row(5, -25601, 0, 0, 2, 0, -32768, 1, 1, 5, 1)};
    plan = {plan, plan_row(6, -25601, 0, 0, 1, 0, -32768, 1, 1, 0, 0)};
    plan = {plan, plan_row(7, 0, 25602, 0, 0, 4, 0, 1, 1, 7, 1)};
    plan = {plan, plan_row(8, 0, 25602, 0, 0, 3, 0, 1, 1, 0, 0)};
    // A frame that sorts: extreme fields, equal ranks at different distances,
    // and two lights with identical keys that must keep arrival order.
    plan = {plan, plan_row('hFFFF, -8388608, 8388607, 8388607, 8388607, 8388607,
                           -32768, 0, 0, 0, 0)};
    plan = {plan, plan_row('h0A01, 100, 0, 0, 0, 0, 5, 0, 0, 0, 0)};
    plan = {plan, plan_row('h0A02, 50, 0, 0, 0, 0, 5, 0, 0, 0, 0)};
    plan = {plan, plan_row('h0A03, 100, 0, 0, 0, 0, 5, 0, 0, 0, 0)};
    plan = {plan, plan_row('h0A04, 25600, 25600, 0, 0, 0, 7, 0, 0, 0, 0)};
    plan = {plan, plan_row('h0A05, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0)};
    plan = {plan, plan_row('h0A06, -100, -50, 0, 0, 0, 32767, 1, 0, 0, 0)};
    // Corner touch, and boxes that reach the view only through a huge reach.
    plan = {plan, plan_row('h00F0, -25600, -25600, 0, 0, 0, 0, 1, 1, 'h00F0, 1)};
    plan = {plan, plan_row('h00F1, 8388607, 0, 8388607, 0, 0, 0, 1, 1, 'h00F1, 1)};
    plan = {plan, plan_row('h00F2, 0, -8388608, 8388607, 0, 8388607, 0, 1, 1,
                           'h00F2, 1)};
    foreach (plan[k]) send_light(plan[k].l, plan[k].typed, plan[k].pick);

    // Random part: six view settings, two per handshake mix. Most lights are
    // placed around the camera so that both culling and sorting get work.
    for (seg = 0; seg < 6; seg++) begin
      drain();
      case (seg / 2)
        0: begin snd_idle_pct = 13; rcv_idle_pct = 63; end
        1: begin snd_idle_pct = 63; rcv_idle_pct = 13; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      case (seg)
        0: set_view(int'($urandom_range(0, 131072)) - 65536,
                    int'($urandom_range(0, 131072)) - 65536,
                    int'($urandom_range(12800, 102400)), int'($urandom_range(12800, 102400)),
                    int'($urandom_range(0, 25600)), 1'b0);
        1: set_view(-8388608, 8388607, 8388607, 0, 0, 1'b0);
        2: set_view(int'($urandom_range(0, 16777215)) - 8388608,
                    int'($urandom_range(0, 16777215)) - 8388608,
                    int'($urandom_range(0, 8388607)), int'($urandom_range(0, 8388607)),
                    8388607, 1'b1);
        3: set_view(0, 0, int'($urandom_range(2560, 25600)),
                    int'($urandom_range(2560, 25600)), 0, 1'b0);
        4: set_view(int'($urandom_range(0, 16777215)) - 8388608,
                    int'($urandom_range(0, 16777215)) - 8388608,
                    int'($urandom_range(0, 51200)), int'($urandom_range(0, 51200)),
                    int'($urandom_range(0, 25600)), 1'b1);
        default: set_view(8388607, -8388608, int'($urandom_range(12800, 102400)),
                          int'($urandom_range(12800, 102400)), 25600, 1'b0);
      endcase
      // Stall the output for a long stretch while lights keep coming, so the
      // block has to hold off its input behind a finished frame.
      if (seg == 3) hold_req = 1'b1;
      seg_lights = 0;
      while (seg_lights < SegLights) begin
        // Now and then a frame long enough to overflow the store; with culling
        // off the first frame of that setting always does.
        if ($urandom_range(0, 9) == 0 || (seg == 4 && seg_lights == 0))
          flen = int'($urandom_range(MaxSel + 1, MaxSel + 12));
        else
          flen = int'($urandom_range(1, 8));
        for (j = 0; j < flen; j++) begin
          kind    = int'($urandom_range(0, 9));
          lt.id   = actk_pkg::IdW'($urandom);
          lt.last = (j == flen - 1);
          if (kind == 0) begin
            // Noise over the full range of every field.
            lt.px    = actk_pkg::CoordW'($urandom);
            lt.py    = actk_pkg::CoordW'($urandom);
            lt.reach = actk_pkg::LenW'($urandom);
            lt.sx    = actk_pkg::LenW'($urandom);
            lt.sy    = actk_pkg::LenW'($urandom);
            lt.rank  = actk_pkg::RankW'($urandom);
          end else begin
            spx = v_half_w + v_margin + 2048;
            spy = v_half_h + v_margin + 2048;
            if (kind == 1) begin
              // Coarse grid near the camera: many equal distances.
              lt.px = actk_pkg::CoordW'(v_cam_x +
                                        256 * (longint'($urandom_range(0, 4)) - 2));
              lt.py = actk_pkg::CoordW'(v_cam_y +
                                        256 * (longint'($urandom_range(0, 4)) - 2));
            end else begin
              lt.px = actk_pkg::CoordW'(v_cam_x +
                                        longint'($urandom_range(0, 32'(2 * spx))) - spx);
              lt.py = actk_pkg::CoordW'(v_cam_y +
                                        longint'($urandom_range(0, 32'(2 * spy))) - spy);
            end
            lt.reach = actk_pkg::LenW'($urandom_range(0, 1024));
            lt.sx    = actk_pkg::LenW'($urandom_range(0, 2048));
            lt.sy    = actk_pkg::LenW'($urandom_range(0, 2048));
            // A handful of ranks so that ties are common.
            lt.rank  = actk_pkg::RankW'(int'($urandom_range(0, 4)) - 2);
          end
          send_light(lt, 1'b0, '0);
        end
        seg_lights += flen;
      end
    end

    drain();
    $display("Covered %0d lights in %0d frames over six view settings and three",
             lights_sent, frames_sent);
    $display("handshake mixes: %0d ids checked, %0d empty frames, %0d overflowing frames.",
             picks_seen, empty_frames, overflow_frames);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
